// ===== design/mtmv_pkg.sv =====
// Shared types and constants for the max-times matrix-vector block.
// No dependencies; imported by every module of the block.
package mtmv_pkg;

  localparam int SITE_W      = 6;
  localparam int TERM_W      = 8;
  localparam int VAL_W       = 32;
  localparam int PROD_W      = 2 * VAL_W;
  localparam int FRAC_W      = 16;
  localparam int SITES_CFG_W = 7;
  localparam int TERMS_CFG_W = 9;
  localparam int APB_AW      = 3;
  localparam int APB_DW      = 32;

  localparam int DEF_NUM_SITES = 64;
  localparam int DEF_NUM_TERMS = 256;

  localparam logic [SITES_CFG_W-1:0] SITES_RESET = 7'd64;
  localparam logic [TERMS_CFG_W-1:0] TERMS_RESET = 9'd256;

  localparam logic CMD_WEIGHT = 1'b0;
  localparam logic CMD_VECTOR = 1'b1;

  localparam logic REG_SITES = 1'b0;
  localparam logic REG_TERMS = 1'b1;

  typedef struct packed {
    logic [SITES_CFG_W-1:0] ns;
    logic [TERMS_CFG_W-1:0] nt;
  } cfg_t;

  typedef struct packed {
    logic              w_en;
    logic              v_en;
    logic [SITE_W-1:0] site;
    logic [TERM_W-1:0] term;
    logic [VAL_W-1:0]  value;
  } wr_req_t;

  typedef struct packed {
    logic              en;
    logic [SITE_W-1:0] site;
    logic [TERM_W-1:0] term;
  } rd_req_t;

  typedef struct packed {
    logic [VAL_W-1:0] weight;
    logic [VAL_W-1:0] vec;
  } rd_data_t;

endpackage

// ===== design/mtmv_if.sv =====
// Valid/ready channel interfaces for load items and per-site results.
// Depends on mtmv_pkg for field widths.
interface mtmv_in_if import mtmv_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [SITE_W-1:0] site_index;
  logic [TERM_W-1:0] term_index;
  logic [VAL_W-1:0]  value;

  modport source (output valid, cmd, site_index, term_index, value, input ready);
  modport sink   (input valid, cmd, site_index, term_index, value, output ready);
endinterface

interface mtmv_out_if import mtmv_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SITE_W-1:0] out_site;
  logic [VAL_W-1:0]  max_value;
  logic              no_term;
  logic              last_site;

  modport source (output valid, out_site, max_value, no_term, last_site, input ready);
  modport sink   (input valid, out_site, max_value, no_term, last_site, output ready);
endinterface

// ===== design/mtmv_cfg.sv =====
// APB register file holding sites_in_use and terms_in_use, with clamping.
// Depends on mtmv_pkg.
module mtmv_cfg import mtmv_pkg::*; #(
  parameter int NUM_SITES = DEF_NUM_SITES,
  parameter int NUM_TERMS = DEF_NUM_TERMS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [SITES_CFG_W-1:0] sites_r;
  logic [TERMS_CFG_W-1:0] terms_r;
  logic                   wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sites_r <= SITES_RESET;
      terms_r <= TERMS_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        REG_SITES: sites_r <= pwdata[SITES_CFG_W-1:0];
        REG_TERMS: terms_r <= pwdata[TERMS_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_SITES: prdata = APB_DW'(sites_r);
      REG_TERMS: prdata = APB_DW'(terms_r);
      default:   prdata = '0;
    endcase
  end

  // clamp to 1..NUM_SITES and 1..NUM_TERMS
  always_comb begin
    if (sites_r == '0) begin
      cfg.ns = SITES_CFG_W'(1);
    end else if (32'(sites_r) > NUM_SITES) begin
      cfg.ns = SITES_CFG_W'(NUM_SITES);
    end else begin
      cfg.ns = sites_r;
    end
    if (terms_r == '0) begin
      cfg.nt = TERMS_CFG_W'(1);
    end else if (32'(terms_r) > NUM_TERMS) begin
      cfg.nt = TERMS_CFG_W'(NUM_TERMS);
    end else begin
      cfg.nt = terms_r;
    end
  end

endmodule

// ===== design/mtmv_store.sv =====
// Weight and vector memories: one write port from the load path,
// one registered read port for the compute engine. Depends on mtmv_pkg.
module mtmv_store import mtmv_pkg::*; #(
  parameter int NUM_SITES = DEF_NUM_SITES,
  parameter int NUM_TERMS = DEF_NUM_TERMS
) (
  input  logic     clk,
  input  wr_req_t  wr,
  input  rd_req_t  rd,
  output rd_data_t rdat
);

  localparam int SITE_AW = (NUM_SITES > 1) ? $clog2(NUM_SITES) : 1;
  localparam int TERM_AW = (NUM_TERMS > 1) ? $clog2(NUM_TERMS) : 1;
  localparam int W_AW    = SITE_AW + TERM_AW;
  localparam int W_DEPTH = 1 << W_AW;
  localparam int V_DEPTH = 1 << TERM_AW;

  logic [VAL_W-1:0] weight_mem [W_DEPTH];
  logic [VAL_W-1:0] vector_mem [V_DEPTH];

  logic [W_AW-1:0]    w_waddr;
  logic [W_AW-1:0]    w_raddr;
  logic [TERM_AW-1:0] v_waddr;
  logic [TERM_AW-1:0] v_raddr;
  logic [VAL_W-1:0]   weight_r;
  logic [VAL_W-1:0]   vec_r;

  assign w_waddr = {SITE_AW'(wr.site), TERM_AW'(wr.term)};
  assign w_raddr = {SITE_AW'(rd.site), TERM_AW'(rd.term)};
  assign v_waddr = TERM_AW'(wr.term);
  assign v_raddr = TERM_AW'(rd.term);

  always_ff @(posedge clk) begin
    if (wr.w_en) begin
      weight_mem[w_waddr] <= wr.value;
    end
    if (wr.v_en) begin
      vector_mem[v_waddr] <= wr.value;
    end
    if (rd.en) begin
      weight_r <= weight_mem[w_raddr];
      vec_r    <= vector_mem[v_raddr];
    end
  end

  assign rdat.weight = weight_r;
  assign rdat.vec    = vec_r;

endmodule

// ===== design/mtmv_engine.sv =====
// Compute engine: walks sites and terms, multiplies, tracks the running
// maximum and holds the result register. Depends on mtmv_pkg, mtmv_if.
module mtmv_engine import mtmv_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  cfg_t     cfg,
  output rd_req_t  rd,
  input  rd_data_t rdat,
  output logic     busy,
  mtmv_out_if.source out_ch
);

  logic              issuing_r;
  logic [SITE_W-1:0] s_r;
  logic [TERM_W-1:0] k_r;
  logic              d_valid_r, d_first_r, d_last_r;
  logic [SITE_W-1:0] d_site_r;
  logic              m_valid_r, m_first_r, m_last_r, m_nz_r;
  logic [SITE_W-1:0] m_site_r;
  logic [PROD_W-1:0] m_prod_r;
  logic              any_r;
  logic [VAL_W-1:0]  best_r;
  logic              out_valid_r;
  logic [SITE_W-1:0] out_site_r;
  logic [VAL_W-1:0]  out_max_r;
  logic              out_none_r;
  logic              out_last_r;

  logic              adv;
  logic              k_end, s_end;
  logic [VAL_W-1:0]  prod_sat;
  logic              any_cur;
  logic [VAL_W-1:0]  best_cur;
  logic              take;
  logic              any_nxt;
  logic [VAL_W-1:0]  best_nxt;

  // freeze the whole pipeline while a result waits unaccepted
  assign adv   = !out_valid_r || out_ch.ready;
  assign k_end = {1'b0, k_r} == (cfg.nt - TERMS_CFG_W'(1));
  assign s_end = {1'b0, s_r} == (cfg.ns - SITES_CFG_W'(1));

  assign rd.en   = issuing_r && adv;
  assign rd.site = s_r;
  assign rd.term = k_r;

  assign busy = issuing_r || d_valid_r || m_valid_r;

  always_comb begin
    prod_sat = (|m_prod_r[PROD_W-1:FRAC_W+VAL_W]) ? '1 : m_prod_r[FRAC_W+VAL_W-1:FRAC_W];
    any_cur  = m_first_r ? 1'b0 : any_r;
    best_cur = m_first_r ? '0 : best_r;
    take     = m_nz_r && (!any_cur || (prod_sat > best_cur));
    best_nxt = take ? prod_sat : best_cur;
    any_nxt  = any_cur || m_nz_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issuing_r   <= 1'b0;
      d_valid_r   <= 1'b0;
      m_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (start) begin
        issuing_r <= 1'b1;
        s_r       <= '0;
        k_r       <= '0;
      end else if (adv && issuing_r) begin
        if (k_end) begin
          k_r <= '0;
          s_r <= s_r + SITE_W'(1);
          if (s_end) begin
            issuing_r <= 1'b0;
          end
        end else begin
          k_r <= k_r + TERM_W'(1);
        end
      end
      if (adv) begin
        d_valid_r <= issuing_r;
        m_valid_r <= d_valid_r;
      end
      if (adv && m_valid_r && m_last_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_first_r <= k_r == '0;
      d_last_r  <= k_end;
      d_site_r  <= s_r;
      m_first_r <= d_first_r;
      m_last_r  <= d_last_r;
      m_site_r  <= d_site_r;
      m_nz_r    <= rdat.weight != '0;
      m_prod_r  <= PROD_W'(rdat.weight) * PROD_W'(rdat.vec);
      if (m_valid_r) begin
        any_r  <= any_nxt;
        best_r <= best_nxt;
      end
      if (m_valid_r && m_last_r) begin
        out_site_r <= m_site_r;
        out_max_r  <= any_nxt ? best_nxt : '0;
        out_none_r <= !any_nxt;
        out_last_r <= {1'b0, m_site_r} == (cfg.ns - SITES_CFG_W'(1));
      end
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_site  = out_site_r;
  assign out_ch.max_value = out_max_r;
  assign out_ch.no_term   = out_none_r;
  assign out_ch.last_site = out_last_r;

endmodule

// ===== design/max_times_matrix_vector_top.sv =====
// Top level of the max-times matrix-vector block.
// Depends on mtmv_pkg, mtmv_if, mtmv_cfg, mtmv_store and mtmv_engine.
//
// Usage:
//   in_ch transfers load items. cmd selects a weight write (site_index,
//   term_index) or a vector element write (term_index). Each load gives
//   no result, except a vector element at index terms_in_use-1, which
//   starts a pass over the stored matrix.
//   A pass emits one result per site in use on out_ch, sites in order from
//   0, last_site set on the final one. The shared read port of the two
//   memories and the single multiplier limit a pass to one product per
//   cycle while out_ch does not stall. in_ch.ready is low for the pass; it
//   rises once the last result is in the output register.
//   When out_ch stalls with a result waiting, the whole pass holds.
//   Reset clears the registers to sites_in_use 64 and terms_in_use 256 and
//   empties the pipeline; memory contents are undefined until written.
//   Write the registers through the APB port only while the block is idle.
module max_times_matrix_vector_top import mtmv_pkg::*; #(
  parameter int NUM_SITES = DEF_NUM_SITES,
  parameter int NUM_TERMS = DEF_NUM_TERMS
) (
  input  logic              clk,
  input  logic              rst_n,
  mtmv_in_if.sink           in_ch,
  mtmv_out_if.source        out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  cfg_t     cfg;
  wr_req_t  wr;
  rd_req_t  rd;
  rd_data_t rdat;
  logic     busy;
  logic     accept;
  logic     site_ok, term_ok;
  logic     start;

  assign in_ch.ready = !busy;
  assign accept      = in_ch.valid && in_ch.ready;
  assign site_ok     = 32'(in_ch.site_index) < NUM_SITES;
  assign term_ok     = 32'(in_ch.term_index) < NUM_TERMS;

  assign wr.w_en  = accept && (in_ch.cmd == CMD_WEIGHT) && site_ok && term_ok;
  assign wr.v_en  = accept && (in_ch.cmd == CMD_VECTOR) && term_ok;
  assign wr.site  = in_ch.site_index;
  assign wr.term  = in_ch.term_index;
  assign wr.value = in_ch.value;

  assign start = wr.v_en && ({1'b0, in_ch.term_index} == (cfg.nt - TERMS_CFG_W'(1)));

  mtmv_cfg #(
    .NUM_SITES (NUM_SITES),
    .NUM_TERMS (NUM_TERMS)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mtmv_store #(
    .NUM_SITES (NUM_SITES),
    .NUM_TERMS (NUM_TERMS)
  ) u_store (
    .clk  (clk),
    .wr   (wr),
    .rd   (rd),
    .rdat (rdat)
  );

  mtmv_engine u_engine (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .cfg    (cfg),
    .rd     (rd),
    .rdat   (rdat),
    .busy   (busy),
    .out_ch (out_ch)
  );

  a_start_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> !in_ch.ready)
    else $error("input taken in the cycle after a pass started");

  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> !rd.en)
    else $error("input transfer while the engine reads the memories");

  a_empty_site_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.no_term) |-> (out_ch.max_value == '0))
    else $error("empty site reports a nonzero maximum");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Testbench for max_times_matrix_vector_top: loads weights and vector elements, predicts
// the per-site max-times results and checks them. Needs mtmv_pkg, mtmv_if and the RTL.
module tb;
  import mtmv_pkg::*;

  localparam int SETTLE_CYCLES  = 8;
  localparam int END_CYCLES     = 300;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic [SITE_W-1:0] site;
    logic [VAL_W-1:0]  value;
    logic              no_term;
    logic              last;
  } site_result_t;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  mtmv_in_if  in_ch ();
  mtmv_out_if out_ch ();

  max_times_matrix_vector_top dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic [VAL_W-1:0]       wgt_mem   [DEF_NUM_SITES][DEF_NUM_TERMS];
  bit                     wgt_known [DEF_NUM_SITES][DEF_NUM_TERMS];
  logic [VAL_W-1:0]       vec_mem   [DEF_NUM_TERMS];
  bit                     vec_known [DEF_NUM_TERMS];
  logic [SITES_CFG_W-1:0] sites_reg = SITES_RESET;
  logic [TERMS_CFG_W-1:0] terms_reg = TERMS_RESET;
  site_result_t           pending_maxima [$];

  int idle_pct     = 0;
  int stall_pct    = 0;
  int hold_req     = 0;
  int hold_left    = 0;
  int loads_sent   = 0;
  int err_cnt      = 0;
  int quiet_cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int eff_sites();
    if (sites_reg == 0) return 1;
    if (sites_reg > DEF_NUM_SITES) return DEF_NUM_SITES;
    return int'(sites_reg);
  endfunction

  function automatic int eff_terms();
    if (terms_reg == 0) return 1;
    if (terms_reg > DEF_NUM_TERMS) return DEF_NUM_TERMS;
    return int'(terms_reg);
  endfunction

  function automatic logic [VAL_W-1:0] q16_mul(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b);
    logic [PROD_W-1:0] p;
    p = ({{VAL_W{1'b0}}, a} * {{VAL_W{1'b0}}, b}) >> FRAC_W;
    return (p[PROD_W-1:VAL_W] != '0) ? '1 : p[VAL_W-1:0];
  endfunction

  function automatic logic [VAL_W-1:0] rand_val();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return VAL_W'($urandom_range(0, 32'h1FFFF));
      3: return {16'hFFFF, 16'($urandom)};
      default: return VAL_W'($urandom);
    endcase
  endfunction

  // Update the stores; a closing element yields one maximum per site in use.
  function automatic void apply_load(logic cmd, logic [SITE_W-1:0] site,
                                     logic [TERM_W-1:0] term, logic [VAL_W-1:0] val);
    int           ns;
    int           nt;
    int           s;
    int           k;
    bit           found;
    logic [VAL_W-1:0] best;
    logic [VAL_W-1:0] p;
    site_result_t r;
    ns = eff_sites();
    nt = eff_terms();
    if (cmd == CMD_WEIGHT) begin
      wgt_mem[site][term]   = val;
      wgt_known[site][term] = 1'b1;
      return;
    end
    vec_mem[term]   = val;
    vec_known[term] = 1'b1;
    if (int'(term) != nt - 1) return;
    for (s = 0; s < ns; s++) begin
      found = 1'b0;
      best  = '0;
      for (k = 0; k < nt; k++) begin
        if (wgt_mem[s][k] != '0) begin
          p = q16_mul(wgt_mem[s][k], vec_mem[k]);
          if (!found || p > best) best = p;
          found = 1'b1;
        end
      end
      r.site    = SITE_W'(s);
      r.value   = found ? best : '0;
      r.no_term = !found;
      r.last    = (s == ns - 1);
      pending_maxima.push_back(r);
    end
  endfunction

  task automatic send_load(input logic cmd, input logic [SITE_W-1:0] site,
                           input logic [TERM_W-1:0] term, input logic [VAL_W-1:0] val);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.cmd        <= cmd;
    in_ch.site_index <= site;
    in_ch.term_index <= term;
    in_ch.value      <= val;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    apply_load(cmd, site, term, val);
    loads_sent++;
    @(negedge clk);
  endtask

  task automatic wait_quiet();
    in_ch.valid <= 1'b0;
    while (pending_maxima.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Upper bits beyond the register width carry noise.
  task automatic write_reg(input logic reg_sel, input int unsigned value);
    logic [APB_DW-1:0] word;
    wait_quiet();
    word = $urandom;
    if (reg_sel == REG_SITES) word[SITES_CFG_W-1:0] = SITES_CFG_W'(value);
    else word[TERMS_CFG_W-1:0] = TERMS_CFG_W'(value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= APB_AW'({reg_sel, 2'b00});
    pwdata  <= word;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (reg_sel == REG_SITES) sites_reg = word[SITES_CFG_W-1:0];
    else terms_reg = word[TERMS_CFG_W-1:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Fill every entry a pass would read, then send the closing element.
  task automatic close_vector(input logic [VAL_W-1:0] val);
    int ns;
    int nt;
    int s;
    int k;
    ns = eff_sites();
    nt = eff_terms();
    for (s = 0; s < ns; s++)
      for (k = 0; k < nt; k++)
        if (!wgt_known[s][k]) send_load(CMD_WEIGHT, SITE_W'(s), TERM_W'(k), rand_val());
    for (k = 0; k < nt - 1; k++)
      if (!vec_known[k]) send_load(CMD_VECTOR, SITE_W'($urandom), TERM_W'(k), rand_val());
    send_load(CMD_VECTOR, SITE_W'($urandom), TERM_W'(nt - 1), val);
  endtask

  task automatic send_pass();
    int ns;
    int nt;
    int s;
    int k;
    ns = eff_sites();
    nt = eff_terms();
    repeat ($urandom_range(0, 10))
      send_load(CMD_WEIGHT, SITE_W'($urandom_range(0, ns - 1)),
                TERM_W'($urandom_range(0, nt - 1)), rand_val());
    if ($urandom_range(3) == 0) begin
      s = $urandom_range(0, ns - 1);
      for (k = 0; k < nt; k++) send_load(CMD_WEIGHT, SITE_W'(s), TERM_W'(k), '0);
    end
    for (k = 0; k < nt - 1; k++)
      if ($urandom_range(1) != 0)
        send_load(CMD_VECTOR, SITE_W'($urandom), TERM_W'(k), rand_val());
    close_vector(rand_val());
  endtask

  task automatic send_noise();
    logic              cmd;
    logic [TERM_W-1:0] term;
    logic [VAL_W-1:0]  val;
    cmd  = 1'($urandom);
    term = TERM_W'($urandom);
    val  = rand_val();
    if (cmd == CMD_VECTOR && int'(term) == eff_terms() - 1) close_vector(val);
    else send_load(cmd, SITE_W'($urandom), term, val);
  endtask

  task automatic pick_config();
    if ($urandom_range(3) == 0) begin
      write_reg(REG_SITES, $urandom_range(65, 127));
      write_reg(REG_TERMS, $urandom_range(0, 2));
    end else begin
      write_reg(REG_SITES, $urandom_range(0, 8));
      write_reg(REG_TERMS, $urandom_range(0, 8));
    end
  endtask

  task automatic test_directed();
    idle_pct  = 0;
    stall_pct = 0;
    write_reg(REG_SITES, 3);
    write_reg(REG_TERMS, 3);
    // site 0 saturates, site 1 is empty, site 2 has nonzero weights
    send_load(CMD_WEIGHT, 6'd0, 8'd0, 32'hFFFF_FFFF);
    send_load(CMD_WEIGHT, 6'd0, 8'd1, 32'h0000_0000);
    send_load(CMD_WEIGHT, 6'd0, 8'd2, 32'h0000_0001);
    send_load(CMD_WEIGHT, 6'd1, 8'd0, 32'h0000_0000);
    send_load(CMD_WEIGHT, 6'd1, 8'd1, 32'h0000_0000);
    send_load(CMD_WEIGHT, 6'd1, 8'd2, 32'h0000_0000);
    send_load(CMD_WEIGHT, 6'd2, 8'd0, 32'h0000_0000);
    send_load(CMD_WEIGHT, 6'd2, 8'd1, 32'h0000_0001);
    send_load(CMD_WEIGHT, 6'd2, 8'd2, 32'h0002_0000);
    send_load(CMD_VECTOR, 6'd63, 8'd0, 32'hFFFF_FFFF);
    send_load(CMD_VECTOR, 6'd0, 8'd1, 32'h0001_0000);
    send_load(CMD_VECTOR, 6'd0, 8'd2, 32'h0000_0000);
    // reuse the stored matrix with a changed vector
    send_load(CMD_VECTOR, 6'd0, 8'd0, 32'h0000_8000);
    send_load(CMD_VECTOR, 6'd0, 8'd2, 32'hFFFF_FFFF);
    send_load(CMD_WEIGHT, 6'd63, 8'd255, rand_val());
    send_load(CMD_VECTOR, 6'd0, 8'd255, rand_val());
  endtask

  task automatic test_register_extremes();
    idle_pct  = 0;
    stall_pct = 16;
    write_reg(REG_SITES, 0);
    write_reg(REG_TERMS, 6);
    close_vector(rand_val());
    write_reg(REG_SITES, 1);
    write_reg(REG_TERMS, 8);
    close_vector(rand_val());
    write_reg(REG_SITES, 127);
    write_reg(REG_TERMS, 0);
    close_vector(rand_val());
    write_reg(REG_SITES, 64);
    write_reg(REG_TERMS, 1);
    send_pass();
  endtask

  task automatic test_random_traffic(input int idle, input int stall, input int count);
    int stop;
    idle_pct  = idle;
    stall_pct = stall;
    stop      = loads_sent + count;
    pick_config();
    while (loads_sent < stop) begin
      if ($urandom_range(4) == 0) pick_config();
      if ($urandom_range(3) == 0) send_noise();
      else send_pass();
    end
  endtask

  task automatic test_backpressure();
    idle_pct  = 0;
    stall_pct = 0;
    write_reg(REG_SITES, 8);
    write_reg(REG_TERMS, 2);
    hold_req = HOLD_CYCLES;
    send_pass();
    repeat (20) send_noise();
    send_pass();
  endtask

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    site_result_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_maxima.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected result: site %0d max %h no_term %b last %b", $time,
                 out_ch.out_site, out_ch.max_value, out_ch.no_term, out_ch.last_site);
      end else begin
        want = pending_maxima.pop_front();
        if (out_ch.out_site !== want.site || out_ch.max_value !== want.value ||
            out_ch.no_term !== want.no_term || out_ch.last_site !== want.last) begin
          err_cnt++;
          $display("%0t: mismatch: expected site %0d max %h no_term %b last %b", $time,
                   want.site, want.value, want.no_term, want.last);
          $display("%0t:           got site %0d max %h no_term %b last %b", $time,
                   out_ch.out_site, out_ch.max_value, out_ch.no_term, out_ch.last_site);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) ||
        (psel && penable && pready === 1'b1))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("tb: done, errors");
    $finish;
  end

  initial begin
    clk              = 1'b0;
    rst_n            = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    in_ch.valid      = 1'b0;
    in_ch.cmd        = CMD_WEIGHT;
    in_ch.site_index = '0;
    in_ch.term_index = '0;
    in_ch.value      = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_register_extremes();
    test_random_traffic(0, 0, 65);
    test_random_traffic(69, 0, 65);
    test_random_traffic(0, 69, 65);
    test_random_traffic(16, 16, 65);
    test_backpressure();
    wait_quiet();
    repeat (END_CYCLES) @(posedge clk);
    if (err_cnt == 0 && pending_maxima.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/mtmv_pkg.sv
design/mtmv_if.sv
design/mtmv_cfg.sv
design/mtmv_store.sv
design/mtmv_engine.sv
design/max_times_matrix_vector_top.sv
bench/tb.sv
